// File: src/jsu_pkg.sv
// Package for the JSON string unescaper: phase codes, state and result types,
// character constants and the small helper functions for hex and UTF-8.
// No dependencies.
`default_nettype none

package jsu_pkg;

  localparam int MAX_RES = 6;

  typedef enum logic [3:0] {
    PH_SEEK   = 4'd0,
    PH_STR    = 4'd1,
    PH_ESC    = 4'd2,
    PH_HEX    = 4'd3,
    PH_HI     = 4'd4,
    PH_HI_BS  = 4'd5,
    PH_LO_HEX = 4'd6
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  digit_count;
    logic [15:0] code_value;
    logic        digits_stopped;
    logic [15:0] held_surrogate;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:          PH_SEEK,
    digit_count:    3'd0,
    code_value:     16'h0000,
    digits_stopped: 1'b0,
    held_surrogate: 16'h0000
  };

  // One result as it leaves the block, without the run_last mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       string_done;
    logic [1:0] end_status;
  } res_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // End status codes.
  localparam logic [1:0] ST_CLOSED     = 2'd0;
  localparam logic [1:0] ST_NOT_STRING = 2'd1;
  localparam logic [1:0] ST_UNTERM     = 2'd2;

  // Characters.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_U     = 8'h75;

  // Surrogate bounds and UTF-8 constants.
  localparam logic [15:0] SUR_HI_BASE = 16'hD800;
  localparam logic [15:0] SUR_LO_BASE = 16'hDC00;
  localparam logic [15:0] SUR_LO_END  = 16'hE000;
  localparam logic [20:0] CP_1BYTE    = 21'h00080;
  localparam logic [20:0] CP_2BYTE    = 21'h00800;
  localparam logic [20:0] CP_3BYTE    = 21'h10000;
  localparam logic [7:0]  LEAD2       = 8'hC0;
  localparam logic [7:0]  LEAD3       = 8'hE0;
  localparam logic [7:0]  LEAD4       = 8'hF0;
  localparam logic [7:0]  CONT        = 8'h80;

  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // Encodes a code point as UTF-8; byte 0 is sent first.
  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t e;
    e.bytes = '0;
    if (cp < CP_1BYTE) begin
      e.bytes[0] = cp[7:0];
      e.len      = 3'd1;
    end else if (cp < CP_2BYTE) begin
      e.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
      e.bytes[1] = CONT | {2'b00, cp[5:0]};
      e.len      = 3'd2;
    end else if (cp < CP_3BYTE) begin
      e.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
      e.bytes[1] = CONT | {2'b00, cp[11:6]};
      e.bytes[2] = CONT | {2'b00, cp[5:0]};
      e.len      = 3'd3;
    end else begin
      e.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
      e.bytes[1] = CONT | {2'b00, cp[17:12]};
      e.bytes[2] = CONT | {2'b00, cp[11:6]};
      e.bytes[3] = CONT | {2'b00, cp[5:0]};
      e.len      = 3'd4;
    end
    return e;
  endfunction

  function automatic logic is_high_sur(input logic [15:0] v);
    return (v >= SUR_HI_BASE) && (v < SUR_LO_BASE);
  endfunction

endpackage

`default_nettype wire

// File: src/jsu_if.sv
// Handshake channel interfaces for the JSON string unescaper: the text input
// channel and the decoded result channel. No dependencies.
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       string_done;
  logic [1:0] end_status;
  logic       run_last;

  modport source (output valid, output data_byte, output byte_valid, output string_done,
                  output end_status, output run_last, input ready);
  modport sink (input valid, input data_byte, input byte_valid, input string_done,
                input end_status, input run_last, output ready);
endinterface

`default_nettype wire

// File: src/jsu_decode.sv
// Combinational step of the unescaper: from the current state and one text
// byte it forms the next state and the list of results. Uses jsu_pkg.
`default_nettype none

module jsu_decode
  import jsu_pkg::*;
(
  input  state_t               st,
  input  logic [7:0]           text_byte,
  input  logic                 text_end,
  output state_t               st_nxt,
  output res_t [MAX_RES-1:0]   res_list,
  output logic [2:0]           res_cnt
);

  // The results of one step are: the held surrogate (three bytes) if pre_en,
  // then the middle part (one raw byte or one encoded code point) if mid_en,
  // then the string end marker if done_en.
  logic        pre_en;
  logic        mid_en;
  logic        mid_raw;
  logic [7:0]  mid_byte;
  logic [20:0] mid_cp;
  logic        done_en;
  logic [1:0]  done_status;
  state_t      st_work;

  hex_t        hv;
  logic [15:0] hex_code;
  logic        hex_stop;
  logic [2:0]  hex_cnt;
  logic        hex_done;
  logic [7:0]  esc_byte;
  logic        is_ws;

  always_comb begin
    hv       = hex_val(text_byte);
    hex_code = (!st.digits_stopped && hv.ok) ? {st.code_value[11:0], hv.val} : st.code_value;
    hex_stop = st.digits_stopped | ~hv.ok;
    hex_cnt  = st.digit_count + 3'd1;
    hex_done = hex_cnt[2];
    is_ws    = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
               (text_byte == CH_CR) || (text_byte == CH_LF);
    case (text_byte)
      CH_N:    esc_byte = CH_LF;
      CH_T:    esc_byte = CH_TAB;
      CH_R:    esc_byte = CH_CR;
      default: esc_byte = text_byte;
    endcase
  end

  always_comb begin
    pre_en      = 1'b0;
    mid_en      = 1'b0;
    mid_raw     = 1'b1;
    mid_byte    = text_byte;
    mid_cp      = '0;
    done_en     = 1'b0;
    done_status = ST_CLOSED;
    st_work     = st;

    case (st.phase)
      PH_STR: begin
        if (text_end) begin
          done_en     = 1'b1;
          done_status = ST_UNTERM;
        end else if (text_byte == CH_QUOTE) begin
          done_en = 1'b1;
        end else if (text_byte == CH_BSL) begin
          st_work.phase = PH_ESC;
        end else begin
          mid_en        = 1'b1;
          st_work.phase = PH_STR;
        end
      end
      PH_ESC: begin
        if (text_end) begin
          mid_en      = 1'b1;
          mid_byte    = CH_BSL;
          done_en     = 1'b1;
          done_status = ST_UNTERM;
        end else if (text_byte == CH_U) begin
          st_work.phase          = PH_HEX;
          st_work.digit_count    = 3'd0;
          st_work.code_value     = 16'h0000;
          st_work.digits_stopped = 1'b0;
        end else begin
          mid_en        = 1'b1;
          mid_byte      = esc_byte;
          st_work.phase = PH_STR;
        end
      end
      PH_HEX: begin
        if (text_end) begin
          done_en     = 1'b1;
          done_status = ST_UNTERM;
        end else begin
          st_work.code_value     = hex_code;
          st_work.digits_stopped = hex_stop;
          st_work.digit_count    = hex_cnt;
          if (hex_done) begin
            if (is_high_sur(hex_code)) begin
              st_work.held_surrogate = hex_code;
              st_work.phase          = PH_HI;
            end else begin
              mid_en        = 1'b1;
              mid_raw       = 1'b0;
              mid_cp        = {5'b00000, hex_code};
              st_work.phase = PH_STR;
            end
          end
        end
      end
      PH_HI: begin
        if (text_end) begin
          pre_en      = 1'b1;
          done_en     = 1'b1;
          done_status = ST_UNTERM;
        end else if (text_byte == CH_BSL) begin
          st_work.phase = PH_HI_BS;
        end else begin
          pre_en = 1'b1;
          if (text_byte == CH_QUOTE) begin
            done_en = 1'b1;
          end else begin
            mid_en        = 1'b1;
            st_work.phase = PH_STR;
          end
        end
      end
      PH_HI_BS: begin
        if (text_end) begin
          pre_en      = 1'b1;
          mid_en      = 1'b1;
          mid_byte    = CH_BSL;
          done_en     = 1'b1;
          done_status = ST_UNTERM;
        end else if (text_byte == CH_U) begin
          st_work.phase          = PH_LO_HEX;
          st_work.digit_count    = 3'd0;
          st_work.code_value     = 16'h0000;
          st_work.digits_stopped = 1'b0;
        end else begin
          pre_en        = 1'b1;
          mid_en        = 1'b1;
          mid_byte      = esc_byte;
          st_work.phase = PH_STR;
        end
      end
      PH_LO_HEX: begin
        if (text_end) begin
          pre_en      = 1'b1;
          done_en     = 1'b1;
          done_status = ST_UNTERM;
        end else begin
          st_work.code_value     = hex_code;
          st_work.digits_stopped = hex_stop;
          st_work.digit_count    = hex_cnt;
          if (hex_done) begin
            if (!hex_stop && hex_code >= SUR_LO_BASE && hex_code < SUR_LO_END) begin
              // Valid pair: 0x10000 plus the two ten-bit halves side by side.
              mid_en        = 1'b1;
              mid_raw       = 1'b0;
              mid_cp        = CP_3BYTE + {1'b0, st.held_surrogate[9:0], hex_code[9:0]};
              st_work.phase = PH_STR;
            end else begin
              pre_en = 1'b1;
              if (is_high_sur(hex_code)) begin
                st_work.held_surrogate = hex_code;
                st_work.phase          = PH_HI;
              end else begin
                mid_en        = 1'b1;
                mid_raw       = 1'b0;
                mid_cp        = {5'b00000, hex_code};
                st_work.phase = PH_STR;
              end
            end
          end
        end
      end
      default: begin
        if (text_end) begin
          done_en     = 1'b1;
          done_status = ST_NOT_STRING;
        end else if (is_ws) begin
          st_work.phase = PH_SEEK;
        end else if (text_byte == CH_QUOTE) begin
          st_work.phase = PH_STR;
        end else begin
          done_en     = 1'b1;
          done_status = ST_NOT_STRING;
        end
      end
    endcase

    st_nxt = done_en ? STATE_RESET : st_work;
  end

  // Lay out the three parts over the result slots.
  utf8_t      enc_pre;
  utf8_t      enc_mid;
  logic [2:0] pre_n;
  logic [2:0] mid_n;
  logic [2:0] mid_idx;
  logic [2:0] slot;

  always_comb begin
    enc_pre = utf8_enc({5'b00000, st.held_surrogate});
    enc_mid = utf8_enc(mid_cp);
    pre_n   = pre_en ? 3'd3 : 3'd0;
    mid_n   = !mid_en ? 3'd0 : (mid_raw ? 3'd1 : enc_mid.len);
    res_cnt = pre_n + mid_n + {2'b00, done_en};
    for (int k = 0; k < MAX_RES; k++) begin
      slot        = 3'(k);
      mid_idx     = slot - pre_n;
      res_list[k] = '0;
      if (slot < pre_n) begin
        res_list[k].data_byte  = enc_pre.bytes[slot[1:0]];
        res_list[k].byte_valid = 1'b1;
      end else if (slot < pre_n + mid_n) begin
        res_list[k].data_byte  = mid_raw ? mid_byte : enc_mid.bytes[mid_idx[1:0]];
        res_list[k].byte_valid = 1'b1;
      end else if (done_en && slot == pre_n + mid_n) begin
        res_list[k].string_done = 1'b1;
        res_list[k].end_status  = done_status;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/jsu_outbuf.sv
// Result register of the unescaper: holds the results of one text byte and
// hands them out one request at a time. Uses jsu_pkg and jsu_out_if.
`default_nettype none

module jsu_outbuf
  import jsu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  res_t [MAX_RES-1:0] res_list,
  input  logic [2:0]         res_cnt,
  output logic               free,
  jsu_out_if.source          out_chan
);

  res_t [MAX_RES-1:0] list_r;
  logic [2:0]         cnt_r;
  logic [2:0]         idx_r;
  logic [2:0]         idx_nxt;
  logic               busy_r;
  logic               busy_nxt;
  logic               take;
  logic               last;

  assign last = (idx_r == 3'(cnt_r - 3'd1));
  assign take = busy_r && out_chan.ready;
  // A new list may come in while the last waiting result is taken.
  assign free = !busy_r || (take && last);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (take) begin
      idx_nxt = idx_r + 3'd1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = (res_cnt != 3'd0);
      idx_nxt  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      if (load) begin
        cnt_r <= res_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      list_r <= res_list;
    end
  end

  assign out_chan.valid       = busy_r;
  assign out_chan.data_byte   = list_r[idx_r].data_byte;
  assign out_chan.byte_valid  = list_r[idx_r].byte_valid;
  assign out_chan.string_done = list_r[idx_r].string_done;
  assign out_chan.end_status  = list_r[idx_r].end_status;
  assign out_chan.run_last    = last;

endmodule

`default_nettype wire

// File: src/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper: input register, decode state and
// the result register. Uses jsu_pkg, jsu_if, jsu_decode and jsu_outbuf.
`default_nettype none

// The block reads JSON text one byte per request and returns the decoded
// string bytes as UTF-8, one result per request, with a closing marker for
// each string that tells whether it was closed by a quote, was not a string
// at all, or ran into the end of the text. Each text byte is caught in an
// input register, decoded in a single combinational step against the parser
// state, and its results (zero to six of them) are loaded into the result
// register together. A text byte that yields zero or one result does not hold
// up the next byte, so plain text streams at one byte per clock while the
// result side is ready; a byte that yields n results holds the decode stage
// until all n are taken, since the result port passes one result per cycle
// while it is ready. The input stays ready while results wait, as long as the
// input register can move on, and a stall on the result side only backs up
// through these two registers. A high surrogate from a \u escape is kept in
// the state until the following text shows whether it pairs; the results for
// it therefore come with the byte that settles it.
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_chan,
  jsu_out_if.source out_chan
);

  // Input register.
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       adv;
  logic       buf_free;

  // Parser state.
  state_t     st_r;
  state_t     st_nxt;

  res_t [MAX_RES-1:0] res_list;
  logic [2:0]         res_cnt;

  // The held byte moves on when the result register can take its results.
  assign adv           = in_valid_r && buf_free;
  assign in_chan.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.text_byte;
      in_end_r  <= in_chan.text_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  jsu_decode u_decode (
    .st        (st_r),
    .text_byte (in_byte_r),
    .text_end  (in_end_r),
    .st_nxt    (st_nxt),
    .res_list  (res_list),
    .res_cnt   (res_cnt)
  );

  jsu_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv),
    .res_list (res_list),
    .res_cnt  (res_cnt),
    .free     (buf_free),
    .out_chan (out_chan)
  );

  // A held text byte that cannot move on stays in place.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(in_byte_r) && $stable(in_end_r)))
    else $error("input register lost a waiting text byte");

  // The string end marker never carries a byte.
  a_done_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.string_done) |-> !out_chan.byte_valid)
    else $error("string end result also carries a byte");

  // Parser state moves only when a byte is decoded.
  a_state_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st_r))
    else $error("parser state changed without a decoded byte");

  // Reset leaves no result pending and the parser seeking a string.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (!out_chan.valid && st_r.phase == PH_SEEK))
    else $error("results or state left over after reset");

endmodule

`default_nettype wire
